### hdl/skht_pkg.sv
package skht_pkg;

  localparam logic [31:0] HASH_SEED     = 32'd1315423911;
  localparam logic [4:0]  KEY_MAX_BYTES = 5'd19;
  localparam int unsigned KEY_BITS      = 152;

  typedef enum logic [2:0] {
    ST_STORED  = 3'd0,
    ST_UPDATED = 3'd1,
    ST_HIT     = 3'd2,
    ST_MISS    = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef enum logic {
    ACT_PUT = 1'b0,
    ACT_GET = 1'b1
  } action_e;

  typedef struct packed {
    logic               action;
    logic [63:0]        key_lo;
    logic [63:0]        key_mid;
    logic [23:0]        key_hi;
    logic [4:0]         key_length;
    logic signed [31:0] value_in;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] value_out;
  } out_t;

  // One memory word per slot
  typedef struct packed {
    logic               valid;
    logic [63:0]        key_lo;
    logic [63:0]        key_mid;
    logic [23:0]        key_hi;
    logic [4:0]         key_length;
    logic signed [31:0] value;
  } slot_t;

  // Handshake between queue and its neighbors
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HASH,
    F_MOD,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_CMP,
    B_ACT
  } back_state_e;

endpackage

### hdl/skht_front.sv
module skht_front
  import skht_pkg::*;
#(
  parameter int unsigned BUCKETS = 1024,
  parameter int unsigned BW      = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  in_t           in_i,
  input  logic          clear_busy_i,
  input  q_stat_t       q_stat_i,
  output logic          push_o,
  output logic [BW-1:0] bucket_o,
  output in_t           item_o
);

  // floor(2^(32+BW) / BUCKETS) + 1 gives the exact quotient for any 32-bit hash
  localparam logic [63:0] RECIP   = ((64'd1 << (32 + BW)) / 64'(BUCKETS)) + 64'd1;
  localparam logic [32:0] RECIP_M = RECIP[32:0];

  front_state_e state_q, state_d;
  in_t          item_q, item_d;
  logic [31:0]  hash_q, hash_d;
  logic [4:0]   cnt_q, cnt_d;
  logic [BW-1:0] rem_q, rem_d;
  logic [31:0]  quo_q, quo_d;

  logic [4:0]          len_sat;
  logic [KEY_BITS-1:0] key_raw;
  logic [KEY_BITS-1:0] key_msk;
  logic [KEY_BITS-1:0] key_cur;
  logic [7:0]          key_byte;
  logic [31:0]         byte_ext;
  logic [64:0]         quo_full;
  logic [31:0]         rem_full;

  assign len_sat = (in_i.key_length > KEY_MAX_BYTES) ? KEY_MAX_BYTES : in_i.key_length;
  assign key_raw = {in_i.key_hi, in_i.key_mid, in_i.key_lo};

  // drop bytes beyond the key length
  always_comb begin
    for (int i = 0; i < 19; i++) begin
      key_msk[i*8 +: 8] = (5'(i) < len_sat) ? key_raw[i*8 +: 8] : 8'h00;
    end
  end

  assign key_cur  = {item_q.key_hi, item_q.key_mid, item_q.key_lo};
  assign key_byte = key_cur[{cnt_q, 3'b000} +: 8];
  assign byte_ext = {{24{key_byte[7]}}, key_byte};
  assign quo_full = 65'(hash_q) * 65'(RECIP_M);
  assign rem_full = hash_q - quo_q * 32'(BUCKETS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    hash_q <= hash_d;
    cnt_q  <= cnt_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    hash_d     = hash_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    in_stall_o = 1'b1;
    push_o     = 1'b0;
    case (state_q)
      F_IDLE: begin
        in_stall_o = clear_busy_i;
        if (in_valid_i && !clear_busy_i) begin
          item_d.action     = in_i.action;
          item_d.key_lo     = key_msk[63:0];
          item_d.key_mid    = key_msk[127:64];
          item_d.key_hi     = key_msk[151:128];
          item_d.key_length = len_sat;
          item_d.value_in   = in_i.value_in;
          hash_d  = HASH_SEED;
          cnt_d   = 5'd0;
          state_d = F_HASH;
        end
      end
      F_HASH: begin
        // one key byte per cycle
        if (cnt_q == item_q.key_length) begin
          cnt_d   = 5'd0;
          rem_d   = '0;
          state_d = F_MOD;
        end else begin
          hash_d = hash_q ^ ((hash_q << 5) + byte_ext + (hash_q >> 2));
          cnt_d  = cnt_q + 5'd1;
        end
      end
      F_MOD: begin
        // quotient by reciprocal multiplication, then the remainder
        if (cnt_q == 5'd0) begin
          quo_d = 32'(quo_full >> (32 + BW));
          cnt_d = 5'd1;
        end else begin
          rem_d   = BW'(rem_full);
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_stat_i.full) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign bucket_o = rem_q;
  assign item_o   = item_q;

endmodule

### hdl/skht_queue.sv
module skht_queue
  import skht_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  q_ctrl_t          ctrl_i,
  output q_stat_t          stat_o,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] entry_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       count_q;
  logic             do_push, do_pop;

  assign do_push = ctrl_i.push && (count_q != 2'd2);
  assign do_pop  = ctrl_i.pop && (count_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= ~wptr_q;
      end
      if (do_pop) begin
        rptr_q <= ~rptr_q;
      end
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o      = entry_q[rptr_q];
  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);

endmodule

### hdl/skht_back.sv
module skht_back
  import skht_pkg::*;
#(
  parameter int unsigned BUCKETS = 1024,
  parameter int unsigned WAYS    = 4,
  parameter int unsigned BW      = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  q_stat_t       q_stat_i,
  output logic          pop_o,
  input  logic [BW-1:0] bucket_i,
  input  in_t           item_i,
  output logic          clear_busy_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output out_t          out_o
);

  localparam int unsigned SLOTS = BUCKETS * WAYS;
  localparam int unsigned AW    = $clog2(SLOTS);
  localparam int unsigned WCW   = $clog2(WAYS + 1);

  back_state_e state_q, state_d;
  logic [AW-1:0]  clr_addr_q, clr_addr_d;
  logic [WCW-1:0] way_q, way_d;
  logic           found_q, found_d;
  logic [WCW-1:0] found_way_q, found_way_d;
  logic signed [31:0] found_val_q, found_val_d;
  logic           free_q, free_d;
  logic [WCW-1:0] free_way_q, free_way_d;
  logic           out_valid_q, out_valid_d;
  out_t           out_q, out_d;

  slot_t          mem [SLOTS];
  slot_t          rdata_q;
  slot_t          wdata;
  logic           we, re;
  logic [AW-1:0]  waddr, raddr;
  logic           key_match;

  function automatic logic [AW-1:0] slot_addr(logic [BW-1:0] bkt, logic [WCW-1:0] way);
    slot_addr = AW'(32'(bkt) * WAYS + 32'(way));
  endfunction

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign key_match = (rdata_q.key_length == item_i.key_length) &&
                     (rdata_q.key_lo == item_i.key_lo) &&
                     (rdata_q.key_mid == item_i.key_mid) &&
                     (rdata_q.key_hi == item_i.key_hi);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    way_q       <= way_d;
    found_q     <= found_d;
    found_way_q <= found_way_d;
    found_val_q <= found_val_d;
    free_q      <= free_d;
    free_way_q  <= free_way_d;
    out_q       <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    way_d       = way_q;
    found_d     = found_q;
    found_way_d = found_way_q;
    found_val_d = found_val_q;
    free_d      = free_q;
    free_way_d  = free_way_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = clr_addr_q;
    raddr       = slot_addr(bucket_i, way_q);
    wdata.valid      = 1'b1;
    wdata.key_lo     = item_i.key_lo;
    wdata.key_mid    = item_i.key_mid;
    wdata.key_hi     = item_i.key_hi;
    wdata.key_length = item_i.key_length;
    wdata.value      = item_i.value_in;
    pop_o        = 1'b0;
    clear_busy_o = 1'b0;
    case (state_q)
      B_CLEAR: begin
        // invalidate one slot per cycle after reset
        clear_busy_o = 1'b1;
        we           = 1'b1;
        wdata.valid  = 1'b0;
        clr_addr_d   = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(SLOTS - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_stat_i.empty) begin
          way_d   = '0;
          found_d = 1'b0;
          free_d  = 1'b0;
          state_d = B_READ;
        end
      end
      B_READ: begin
        re      = 1'b1;
        state_d = B_CMP;
      end
      B_CMP: begin
        if (rdata_q.valid) begin
          if (!found_q && key_match) begin
            found_d     = 1'b1;
            found_way_d = way_q;
            found_val_d = rdata_q.value;
          end
        end else if (!free_q) begin
          free_d     = 1'b1;
          free_way_d = way_q;
        end
        if (way_q == WCW'(WAYS - 1)) begin
          state_d = B_ACT;
        end else begin
          way_d   = way_q + WCW'(1);
          state_d = B_READ;
        end
      end
      B_ACT: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d     = 1'b1;
          out_d.value_out = '0;
          pop_o           = 1'b1;
          state_d         = B_IDLE;
          if (item_i.action == ACT_PUT) begin
            if (found_q) begin
              we           = 1'b1;
              waddr        = slot_addr(bucket_i, found_way_q);
              out_d.status = ST_UPDATED;
            end else if (free_q) begin
              we           = 1'b1;
              waddr        = slot_addr(bucket_i, free_way_q);
              out_d.status = ST_STORED;
            end else begin
              out_d.status = ST_FULL;
            end
          end else begin
            if (found_q) begin
              out_d.status    = ST_HIT;
              out_d.value_out = found_val_q;
            end else begin
              out_d.status = ST_MISS;
            end
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### hdl/string_key_hash_table_unit.sv
// Key-value store with string keys of up to 19 bytes and 32-bit signed values.
// Input channel (in_valid_i / in_stall_o / in_i): one put or get per item.
// Output channel (out_valid_o / out_stall_i / out_o): one status and value
// per item, in the order the items were taken.
// An item is taken at a rising edge with valid high and stall low.
// The front end hashes the key one byte per cycle, then reduces the hash
// modulo BUCKETS by reciprocal multiplication, first the quotient and then
// the remainder; it takes the next item only after pushing this one.
// A two-entry queue feeds the back end, which reads the bucket's ways from
// the slot memory one at a time and, for a put, writes the matching or a
// free slot. The front end can hash the next item while the back end is
// still working on the previous one. After reset the back end clears the
// valid bit of every slot, one slot per cycle; in_stall_o stays high
// during that pass. When out_stall_i is high the result is held in the
// output register, the back end waits, and the queue and front end fill
// and keep in_stall_o high until results are taken again.
module string_key_hash_table_unit
  import skht_pkg::*;
#(
  parameter int unsigned BUCKETS = 1024,
  parameter int unsigned WAYS    = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  localparam int unsigned BW = $clog2(BUCKETS);
  localparam int unsigned QW = BW + $bits(in_t);

  q_ctrl_t       q_ctrl;
  q_stat_t       q_stat;
  logic          q_push;
  logic          q_pop;
  logic          clear_busy;
  logic [BW-1:0] front_bucket;
  in_t           front_item;
  logic [QW-1:0] q_rdata;
  logic [BW-1:0] back_bucket;
  in_t           back_item;

  assign q_ctrl = '{push: q_push, pop: q_pop};

  skht_front #(
    .BUCKETS(BUCKETS),
    .BW     (BW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .clear_busy_i(clear_busy),
    .q_stat_i    (q_stat),
    .push_o      (q_push),
    .bucket_o    (front_bucket),
    .item_o      (front_item)
  );

  skht_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (q_ctrl),
    .stat_o (q_stat),
    .wdata_i({front_bucket, front_item}),
    .rdata_o(q_rdata)
  );

  assign back_bucket = q_rdata[QW-1 -: BW];
  assign back_item   = q_rdata[$bits(in_t)-1:0];

  skht_back #(
    .BUCKETS(BUCKETS),
    .WAYS   (WAYS),
    .BW     (BW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .pop_o       (q_pop),
    .bucket_i    (back_bucket),
    .item_i      (back_item),
    .clear_busy_o(clear_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule
